@@ rtl/core/wgm_pkg.sv @@
package wgm_pkg;

	localparam int STORE_CHARS     = 16;
	localparam int PATTERN_MAX_DEF = 16;
	localparam int CHAR_W          = 8;
	localparam int CFG_W           = 64;
	localparam int LEN_W           = 5;
	localparam int IDX_W           = 2;

	localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
	localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

	typedef enum logic [IDX_W-1:0] {
		REG_PAT_FIRST  = 2'd0,
		REG_PAT_SECOND = 2'd1,
		REG_PAT_LEN    = 2'd2
	} cfg_reg_t;

	// carries passed from one position cell to the next
	typedef struct packed {
		logic start;
		logic step;
		logic close;
	} link_t;

	typedef struct packed {
		logic active;
		logic load;
		logic clear;
	} cell_ctrl_t;

endpackage

@@ rtl/core/wgm_cell.sv @@
module wgm_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [wgm_pkg::CHAR_W-1:0] pat_char,
	input  logic                       en,
	input  logic                       pos_ok,
	input  logic [wgm_pkg::CHAR_W-1:0] text_char,
	input  wgm_pkg::cell_ctrl_t        ctrl,
	input  wgm_pkg::link_t             link_in,
	output wgm_pkg::link_t             link_out,
	output logic                       cur,
	output logic                       closed
);
	import wgm_pkg::*;

	logic reach_q;
	logic is_star;
	logic hit;

	assign is_star = (pat_char == STAR_CHAR);
	assign hit     = (pat_char == ANY_CHAR) || (pat_char == text_char);

	// position set entering this transaction
	assign cur = ctrl.active ? (reach_q & pos_ok) : link_in.start;

	// a star keeps its own position; a literal or '?' moves one right
	assign closed = (cur & en & is_star) | link_in.step | link_in.close;

	assign link_out.start = link_in.start & en & is_star;
	assign link_out.step  = cur & en & ~is_star & hit;
	assign link_out.close = closed & en & is_star;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= 1'b0;
		end else if (ctrl.clear) begin
			reach_q <= 1'b0;
		end else if (ctrl.load) begin
			reach_q <= closed;
		end
	end

endmodule

@@ rtl/core/wildcard_glob_matcher.sv @@
// Glob matcher, '*' and '?', one subject character per transaction.
// The result of a string is registered and shows in the cycle after its last transaction.
// Throughput: one character per cycle while text_ready is high; the star closure ripples through the cell row.
// Input stalls only when an ending transaction meets a held, untaken result.
// Reset (arst_n low, asynchronous) clears pattern registers, position set and result.
module wildcard_glob_matcher #(
	parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [wgm_pkg::IDX_W-1:0]  cfg_index,
	input  logic [wgm_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       text_valid,
	output logic                       text_ready,
	input  logic [wgm_pkg::CHAR_W-1:0] text_char,
	input  logic                       last_char,
	input  logic                       empty_string,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic                       matched
);
	import wgm_pkg::*;

	localparam int NCELL = (PATTERN_MAX < STORE_CHARS) ? PATTERN_MAX : STORE_CHARS;
	localparam int NPOS  = NCELL + 1;
	localparam int POS_W = $clog2(NPOS);

	logic [CFG_W-1:0] pat_first_q;
	logic [CFG_W-1:0] pat_second_q;
	logic [LEN_W-1:0] pat_len_q;
	logic             inside_q;
	logic             fin_q;
	logic             result_valid_q;
	logic             matched_q;

	logic [LEN_W-1:0] len_sat;
	logic [POS_W-1:0] len;
	logic             accept;
	logic             ending;
	cell_ctrl_t       ctrl;
	link_t            link [NCELL+1];
	logic [NPOS-1:0]  cur_vec;
	logic [NPOS-1:0]  closed_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_first_q  <= '0;
			pat_second_q <= '0;
			pat_len_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PAT_FIRST:  pat_first_q  <= cfg_data;
				REG_PAT_SECOND: pat_second_q <= cfg_data;
				REG_PAT_LEN:    pat_len_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len_sat = (pat_len_q > LEN_W'(NCELL)) ? LEN_W'(NCELL) : pat_len_q;
	assign len     = len_sat[POS_W-1:0];

	assign ending     = last_char | empty_string;
	assign text_ready = ~ending | ~result_valid_q | result_ready;
	assign accept     = text_valid & text_ready;

	assign ctrl.active = inside_q;
	assign ctrl.clear  = accept & ending;
	assign ctrl.load   = accept & ~ending;

	assign link[0] = '{start: 1'b1, step: 1'b0, close: 1'b0};

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic [CHAR_W-1:0] pchar;
		if (i < 8) begin : g_lo
			assign pchar = pat_first_q[i*CHAR_W +: CHAR_W];
		end else begin : g_hi
			assign pchar = pat_second_q[(i-8)*CHAR_W +: CHAR_W];
		end

		wgm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.pat_char  (pchar),
			.en        (len > POS_W'(i)),
			.pos_ok    (len >= POS_W'(i)),
			.text_char (text_char),
			.ctrl      (ctrl),
			.link_in   (link[i]),
			.link_out  (link[i+1]),
			.cur       (cur_vec[i]),
			.closed    (closed_vec[i])
		);
	end

	// end position has no pattern character, only its reach bit
	assign cur_vec[NCELL]    = inside_q ? (fin_q & (len == POS_W'(NCELL))) : link[NCELL].start;
	assign closed_vec[NCELL] = link[NCELL].step | link[NCELL].close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q    <= 1'b0;
			inside_q <= 1'b0;
		end else if (accept) begin
			fin_q    <= ending ? 1'b0 : closed_vec[NCELL];
			inside_q <= ~ending;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			matched_q      <= 1'b0;
		end else if (accept && ending) begin
			result_valid_q <= 1'b1;
			matched_q      <= empty_string ? cur_vec[len] : closed_vec[len];
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign matched      = matched_q;

endmodule

@@ rtl/core/wgm_checker.sv @@
module wgm_checker (
	input logic clk,
	input logic arst_n,
	input logic text_valid,
	input logic text_ready,
	input logic last_char,
	input logic empty_string,
	input logic result_valid,
	input logic result_ready,
	input logic matched
);

	// a held result keeps its value until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(matched))
		else $error("result changed while stalled");

	// an ending transaction always yields a result next cycle
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_ready && (last_char || empty_string) |=> result_valid)
		else $error("ending transaction produced no result");

	// characters inside a string never stall
	a_mid_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !last_char && !empty_string |-> text_ready)
		else $error("mid-string transaction stalled");

	// a new result comes only from an ending transaction
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |->
			$past(text_valid && text_ready && (last_char || empty_string)))
		else $error("result without ending transaction");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);

@@ bench/tb_wildcard_glob_matcher.sv @@
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher;
	import wgm_pkg::*;

	localparam int PMAX        = PATTERN_MAX_DEF;
	localparam int QUIET_LIMIT = 1000;
	localparam int RAND_CHARS  = 1150;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {WANT_PRED, WANT_NO, WANT_YES} want_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_t;

	typedef struct packed {
		row_kind_t   kind;
		cfg_reg_t    idx;
		logic [63:0] data;
		logic [7:0]  ch;
		logic        fin;
		logic        none;
		want_t       want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                text_valid = 1'b0;
	logic                text_ready;
	logic [CHAR_W-1:0]   text_char = '0;
	logic                last_char = 1'b0;
	logic                empty_string = 1'b0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic                matched;

	// predictor copy of the registers and the position set
	logic [63:0] pat_lo = '0;
	logic [63:0] pat_hi = '0;
	logic [4:0]  pat_len = '0;
	logic [16:0] live_set = '0;
	logic        mid_string = 1'b0;

	logic        verdict_q[$];
	want_t       cur_want = WANT_PRED;
	int          fails = 0;
	int          chars_sent = 0;
	int          burst_left = 0;
	int          quiet = 0;
	stall_t      stall_mode = STALL_NONE;
	int          stall_cnt = 0;
	logic        mon_done;
	logic        mon_hit;
	logic        want_bit;
	dir_row_t    dir_rows [0:29];

	wildcard_glob_matcher #(.PATTERN_MAX(PMAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_char(text_char),
		.last_char(last_char),
		.empty_string(empty_string),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.matched(matched)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_len();
		int cap;
		cap = (PMAX < STORE_CHARS) ? PMAX : STORE_CHARS;
		return (int'(pat_len) > cap) ? cap : int'(pat_len);
	endfunction

	function automatic logic [7:0] pat_byte(int i);
		return (i < 8) ? pat_lo[i*8 +: 8] : pat_hi[(i-8)*8 +: 8];
	endfunction

	function automatic logic [16:0] pos_mask(int n);
		logic [17:0] m;
		m = (18'd1 << (n + 1)) - 18'd1;
		return m[16:0];
	endfunction

	function automatic logic [16:0] star_close(logic [16:0] s, int n);
		s = s & pos_mask(n);
		for (int i = 0; i < n; i++)
			if (s[i] && pat_byte(i) == STAR_CHAR)
				s[i+1] = 1'b1;
		return s;
	endfunction

	function automatic logic [16:0] take_char(logic [16:0] s, int n, logic [7:0] c);
		logic [16:0] nxt;
		logic [7:0]  p;
		nxt = '0;
		s = s & pos_mask(n);
		for (int i = 0; i < n; i++) begin
			p = pat_byte(i);
			if (s[i]) begin
				if (p == STAR_CHAR)
					nxt[i] = 1'b1;
				else if (p == ANY_CHAR || p == c)
					nxt[i+1] = 1'b1;
			end
		end
		return star_close(nxt, n);
	endfunction

	task automatic glob_step(input logic [7:0] ch, input logic fin, input logic none,
			output logic done, output logic hit);
		int          n;
		logic [16:0] s;
		n = eff_len();
		s = mid_string ? (live_set & pos_mask(n)) : star_close(17'd1, n);
		if (!none)
			s = take_char(s, n, ch);
		if (none || fin) begin
			done = 1'b1;
			hit = s[n];
			live_set = '0;
			mid_string = 1'b0;
		end else begin
			done = 1'b0;
			hit = 1'b0;
			live_set = s;
			mid_string = 1'b1;
		end
	endtask

	function automatic logic [7:0] pick_letter(int span);
		return 8'h61 + 8'($urandom_range(0, span));
	endfunction

	function automatic logic [7:0] pick_pat_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return STAR_CHAR;
		if (r == 2)
			return ANY_CHAR;
		if (r == 3)
			return 8'($urandom_range(0, 255));
		return pick_letter(2);
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic fin, input logic none,
			input want_t want);
		@(negedge clk);
		if (burst_left == 0) begin
			text_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		text_valid = 1'b1;
		text_char = ch;
		last_char = fin;
		empty_string = none;
		cur_want = want;
		burst_left--;
		chars_sent++;
		do @(posedge clk); while (!(text_valid && text_ready));
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic drain_idle();
		@(negedge clk);
		text_valid = 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
		drain_idle();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_PAT_FIRST:  pat_lo = data;
			REG_PAT_SECOND: pat_hi = data;
			REG_PAT_LEN:    pat_len = data[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_cnt % 64 == 0)
			stall_mode = stall_t'($urandom_range(0, 3));
		stall_cnt++;
		case (stall_mode)
			STALL_NONE:     result_ready = 1'b1;
			STALL_SPARSE:   result_ready = ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: result_ready = (stall_cnt % 5 != 0);
			default:        result_ready = 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (verdict_q.size() == 0) begin
					$error("matched: expected none, actual %0b", matched);
					fails++;
				end else begin
					want_bit = verdict_q.pop_front();
					if (matched !== want_bit) begin
						$error("matched: expected %0b, actual %0b", want_bit, matched);
						fails++;
					end
				end
			end
			if (text_valid && text_ready) begin
				glob_step(text_char, last_char, empty_string, mon_done, mon_hit);
				if (mon_done)
					verdict_q = {verdict_q, ((cur_want == WANT_PRED) ? mon_hit
						: (cur_want == WANT_YES))};
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && text_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		logic [127:0] np;
		logic [7:0]   subj[$];
		logic [7:0]   c;
		int           plen;
		int           kind;
		int           cut;
		dir_rows = '{
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h00, 1'b0, 1'b1, WANT_YES},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h78, 1'b1, 1'b0, WANT_NO},
			'{ROW_CFG,  REG_PAT_FIRST,  64'h0000_0000_623F_2A61, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_CFG,  REG_PAT_LEN,    64'd4, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h61, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h78, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h62, 1'b1, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h61, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h62, 1'b1, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h00, 1'b0, 1'b1, WANT_PRED},
			// empty flag ends a string already in progress
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h61, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'hFF, 1'b1, 1'b1, WANT_PRED},
			// shorten the pattern while a string is open
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h61, 1'b0, 1'b0, WANT_PRED},
			'{ROW_CFG,  REG_PAT_LEN,    64'd1, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h00, 1'b0, 1'b1, WANT_PRED},
			// all stars, length saturates at storage
			'{ROW_CFG,  REG_PAT_FIRST,  64'h2A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_CFG,  REG_PAT_SECOND, 64'h2A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_CFG,  REG_PAT_LEN,    64'd31, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'hFF, 1'b1, 1'b0, WANT_YES},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h00, 1'b0, 1'b1, WANT_YES},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h00, 1'b1, 1'b0, WANT_YES},
			// zero byte as a plain literal in pattern and subject
			'{ROW_CFG,  REG_PAT_FIRST,  64'hFFFF_FFFF_FFFF_FF00, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_CFG,  REG_PAT_SECOND, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_CFG,  REG_PAT_LEN,    64'd2, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'hFF, 1'b1, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h00, 1'b1, 1'b0, WANT_PRED},
			'{ROW_CFG,  REG_PAT_LEN,    64'd0, 8'h00, 1'b0, 1'b0, WANT_PRED},
			'{ROW_ITEM, REG_PAT_FIRST,  64'd0, 8'h00, 1'b1, 1'b0, WANT_NO}
		};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG)
				write_reg(dir_rows[k].idx, dir_rows[k].data);
			else
				send_char(dir_rows[k].ch, dir_rows[k].fin, dir_rows[k].none,
					dir_rows[k].want);
		end

		while (chars_sent < RAND_CHARS + 20) begin
			case ($urandom_range(0, 19))
				0:       plen = 0;
				1:       plen = 16;
				2:       plen = $urandom_range(17, 31);
				default: plen = $urandom_range(1, 8);
			endcase
			for (int i = 0; i < 16; i++)
				np[i*8 +: 8] = pick_pat_byte();
			write_reg(REG_PAT_FIRST, np[63:0]);
			write_reg(REG_PAT_SECOND, np[127:64]);
			write_reg(REG_PAT_LEN, 64'(plen));

			repeat ($urandom_range(4, 14)) begin
				subj.delete();
				// mostly strings built from the pattern, some mutated or cut short
				kind = $urandom_range(0, 9);
				if (kind <= 5 || kind == 9) begin
					for (int i = 0; i < eff_len(); i++) begin
						c = pat_byte(i);
						if (c == STAR_CHAR)
							repeat ($urandom_range(0, 3)) subj = {subj, pick_letter(2)};
						else if (c == ANY_CHAR)
							subj = {subj, (($urandom_range(0, 3) == 0)
								? 8'($urandom_range(0, 255)) : pick_letter(2))};
						else
							subj = {subj, c};
					end
					if (kind <= 5 && subj.size() > 0 && $urandom_range(0, 2) == 0)
						subj[$urandom_range(0, subj.size() - 1)] = pick_letter(3);
				end else if (kind <= 7) begin
					repeat ($urandom_range(0, 8)) subj = {subj, pick_letter(2)};
				end else begin
					repeat ($urandom_range(1, 4)) subj = {subj, 8'($urandom_range(0, 255))};
				end

				if (kind == 9 && subj.size() > 0) begin
					cut = $urandom_range(0, subj.size() - 1);
					for (int j = 0; j < cut; j++)
						send_char(subj[j], 1'b0, 1'b0, WANT_PRED);
					send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
						WANT_PRED);
				end else if (subj.size() == 0) begin
					send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
						WANT_PRED);
				end else begin
					foreach (subj[j])
						send_char(subj[j], j == subj.size() - 1, 1'b0, WANT_PRED);
				end
			end
		end

		@(negedge clk);
		text_valid = 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/wgm_pkg.sv
rtl/core/wgm_cell.sv
rtl/core/wildcard_glob_matcher.sv
rtl/core/wgm_checker.sv
bench/tb_wildcard_glob_matcher.sv
